// ===== src/tpq_pkg.sv =====
package tpq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PrioWidth  = 16;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [1:0] {
    OP_ENQ     = 2'd0,
    OP_DEQ     = 2'd1,
    OP_DEQ_LIM = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;
  } dp_sts_t;

endpackage

// ===== src/tpq_if.sv =====
interface tpq_in_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           opcode;
  logic signed [31:0]   item_value;
  logic signed [15:0]   item_priority;
  modport source (output valid, opcode, item_value, item_priority, input ready);
  modport sink (input valid, opcode, item_value, item_priority, output ready);
endinterface

interface tpq_out_if;
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic signed [31:0]   out_value;
  logic [4:0]           entry_count;
  modport source (output valid, status, out_value, entry_count, input ready);
  modport sink (input valid, status, out_value, entry_count, output ready);
endinterface

// ===== src/tpq_ctrl.sv =====
module tpq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output tpq_pkg::dp_cmd_t cmd,
  input  tpq_pkg::dp_sts_t sts
);
  import tpq_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: if (sts.done) state_nxt = S_OUT;
      S_OUT: begin
        if (out_ready) state_nxt = in_valid ? S_EXEC : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (state_r == S_OUT);
    in_ready  = (state_r == S_IDLE) || ((state_r == S_OUT) && out_ready);
    cmd.load  = in_ready && in_valid;
    cmd.exec  = (state_r == S_EXEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

`ifndef ASSERT_OFF
  a_load_only_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> in_ready) else $error("load without ready");
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && sts.done |=> out_valid) else $error("missing result");
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("no exec after load");
`endif
endmodule

// ===== src/tpq_dp.sv =====
module tpq_dp #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tpq_pkg::dp_cmd_t         cmd,
  output tpq_pkg::dp_sts_t         sts,
  input  logic [1:0]               in_opcode,
  input  logic signed [31:0]       in_value,
  input  logic signed [15:0]       in_priority,
  output logic [1:0]               res_status,
  output logic signed [31:0]       res_value,
  output logic [4:0]               res_count
);
  import tpq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // cell chain: slot 0 is the head
  logic signed [31:0] val_r [CAPACITY];
  logic signed [15:0] pri_r [CAPACITY];
  logic [CntW-1:0]    cnt_r;

  logic [1:0]         op_r;
  logic signed [31:0] ival_r;
  logic signed [15:0] ipri_r;
  logic [1:0]         st_r;
  logic signed [31:0] ov_r;

  // per-cell compare flags
  logic [CAPACITY-1:0] occ, ge, gt, ins_before, take_at, take_before;
  logic signed [31:0]  take_val;
  logic                full, any_take;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CntW'(i) < cnt_r);
      ge[i]  = occ[i] && (pri_r[i] >= ipri_r);
      gt[i]  = occ[i] && (pri_r[i] > ipri_r);
    end
    full = (cnt_r == CntW'(CAPACITY));
    // insert position: first cell not ge (entries are sorted, so ge is a prefix)
    // removal position: head, or first occupied cell not gt
    ins_before[0]  = 1'b1;
    take_before[0] = 1'b1;
    for (int i = 1; i < CAPACITY; i++) begin
      ins_before[i]  = ge[i-1];
      take_before[i] = (op_r == OP_DEQ_LIM) ? gt[i-1] : 1'b0;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      take_at[i] = occ[i] && take_before[i] &&
                   (op_r == OP_DEQ ? 1'b1 : !gt[i]);
    end
    any_take = |take_at;
    take_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (take_at[i]) take_val = val_r[i];
    end
  end

  assign sts.done = cmd.exec;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_opcode;
      ival_r <= in_value;
      ipri_r <= in_priority;
    end
    if (cmd.exec) begin
      st_r <= ST_OK;
      ov_r <= '0;
      case (op_r)
        OP_ENQ: begin
          if (full) st_r <= ST_FULL;
          else begin
            if (!ge[0]) begin
              val_r[0] <= ival_r;
              pri_r[0] <= ipri_r;
            end
            for (int i = 1; i < CAPACITY; i++) begin
              if (!ge[i]) begin
                if (ins_before[i]) begin
                  val_r[i] <= ival_r;
                  pri_r[i] <= ipri_r;
                end else begin
                  val_r[i] <= val_r[i-1];
                  pri_r[i] <= pri_r[i-1];
                end
              end
            end
          end
        end
        OP_DEQ, OP_DEQ_LIM: begin
          if (!any_take) st_r <= ST_EMPTY;
          else begin
            ov_r <= take_val;
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (!(take_before[i] && !take_at[i])) begin
                val_r[i] <= val_r[i+1];
                pri_r[i] <= pri_r[i+1];
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.exec) begin
      if (op_r == OP_ENQ && !full) cnt_r <= cnt_r + 1'b1;
      else if ((op_r == OP_DEQ || op_r == OP_DEQ_LIM) && any_take) cnt_r <= cnt_r - 1'b1;
    end
  end

  assign res_status = st_r;
  assign res_value  = ov_r;
  assign res_count  = 5'(cnt_r);

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(CAPACITY)) else $error("count overflow");
  a_take_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> $onehot0(take_at)) else $error("multiple removals");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == OP_ENQ && full |=> cnt_r == $past(cnt_r))
    else $error("full enqueue changed count");
`endif
endmodule

// ===== src/threshold_priority_queue_top.sv =====
// Threshold priority queue: bounded queue of value/priority entries, highest
// priority at the head, equal priorities kept in arrival order.
// Input channel (in_*): one operation per item - enqueue, dequeue head,
// dequeue the first entry at or below a priority limit, or no-op.
// Output channel (out_*): exactly one result item per operation, carrying
// status, removed value and the entry count after the operation.
// Flow: an accepted item is registered with its opcode, the controller runs
// S_EXEC, where the cell chain compare-and-shift writes the result registers
// directly, and the result is offered in S_OUT. No new item is taken during
// S_EXEC; the next item is accepted in the cycle the current result leaves.
// The cell chain compares every slot in parallel, so timing is independent
// of the entry count.
// Reset (rst_n low, synchronous) empties the queue; slot contents are not
// cleared. A stalled receiver holds the result and blocks new items.
module threshold_priority_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input logic    clk,
  input logic    rst_n,
  tpq_in_if.sink   in_ch,
  tpq_out_if.source out_ch
);
  import tpq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  tpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  tpq_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_opcode   (in_ch.opcode),
    .in_value    (in_ch.item_value),
    .in_priority (in_ch.item_priority),
    .res_status  (out_ch.status),
    .res_value   (out_ch.out_value),
    .res_count   (out_ch.entry_count)
  );
endmodule

// ===== verif/tb_threshold_priority_queue_top.sv =====
`timescale 1ns / 100ps

module tb_threshold_priority_queue_top;
  import tpq_pkg::*;

  localparam int unsigned Depth = 16;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] item_value;
    logic signed [15:0] item_priority;
  } queue_op_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic [4:0]         entry_count;
  } queue_reply_t;

  logic clk;
  logic rst_n;

  tpq_in_if  in_ch();
  tpq_out_if out_ch();

  threshold_priority_queue_top #(.CAPACITY(Depth)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow copy of the queue contents
  logic signed [31:0] shadow_values [Depth];
  logic signed [15:0] shadow_prios  [Depth];
  int unsigned        shadow_fill;

  queue_op_t    pending_ops[$];
  queue_reply_t expected_replies[$];
  int unsigned  error_count;
  int unsigned  ops_issued;
  bit           calm_phase;
  bit           long_hold;
  int           send_idle;
  int           recv_idle;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void remove_slot(int unsigned idx);
    for (int unsigned i = idx; i + 1 < shadow_fill; i++) begin
      shadow_values[i] = shadow_values[i + 1];
      shadow_prios[i]  = shadow_prios[i + 1];
    end
    shadow_fill--;
  endfunction

  function automatic queue_reply_t apply_queue_op(queue_op_t op);
    queue_reply_t r;
    int unsigned  pos;
    r.status    = ST_OK;
    r.out_value = '0;
    pos = 0;
    case (op.opcode)
      OP_ENQ: begin
        if (shadow_fill >= Depth) begin
          r.status = ST_FULL;
        end else begin
          while (pos < shadow_fill && shadow_prios[pos] >= op.item_priority) pos++;
          for (int unsigned i = shadow_fill; i > pos; i--) begin
            shadow_values[i] = shadow_values[i - 1];
            shadow_prios[i]  = shadow_prios[i - 1];
          end
          shadow_values[pos] = op.item_value;
          shadow_prios[pos]  = op.item_priority;
          shadow_fill++;
        end
      end
      OP_DEQ: begin
        if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = shadow_values[0];
          remove_slot(0);
        end
      end
      OP_DEQ_LIM: begin
        while (pos < shadow_fill && shadow_prios[pos] > op.item_priority) pos++;
        if (pos >= shadow_fill) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = shadow_values[pos];
          remove_slot(pos);
        end
      end
      default: ;
    endcase
    r.entry_count = shadow_fill[4:0];
    return r;
  endfunction

  function automatic queue_op_t make_op(logic [1:0] opc, logic [31:0] v, logic [15:0] p);
    queue_op_t op;
    op.opcode        = opc;
    op.item_value    = v;
    op.item_priority = p;
    return op;
  endfunction

  // priorities mostly from a narrow band, plus extremes, so ties and limit hits are common
  function automatic logic [15:0] rand_prio();
    logic [15:0] p;
    case ($urandom_range(0, 3))
      0: p = 16'($urandom);
      1: p = ($urandom_range(0, 1) != 0) ? 16'h7fff : 16'h8000;
      default: p = 16'(int'($urandom_range(0, 14)) - 7);
    endcase
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      send_idle   <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_replies.push_back(apply_queue_op(make_op(in_ch.opcode, in_ch.item_value,
                                                          in_ch.item_priority)));
        ops_issued <= ops_issued + 1;
      end
      if (send_idle > 0) begin
        in_ch.valid <= 1'b0;
        send_idle   <= send_idle - 1;
      end else if (pending_ops.size() != 0 &&
                   !(pending_ops[0].opcode === 2'bxx)) begin
        if (!calm_phase && $urandom_range(0, 7) == 0) begin
          in_ch.valid <= 1'b0;
          send_idle   <= $urandom_range(0, 9);
        end else begin
          queue_op_t op;
          op = pending_ops.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.opcode        <= op.opcode;
          in_ch.item_value    <= op.item_value;
          in_ch.item_priority <= op.item_priority;
        end
      end else begin
        in_ch.valid <= 1'b0;
        // a marker entry holds the sender until every result is back
        if (pending_ops.size() != 0 && expected_replies.size() == 0 && !in_ch.valid)
          void'(pending_ops.pop_front());
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_idle    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result item: status %0d value %0d count %0d",
                 out_ch.status, out_ch.out_value, out_ch.entry_count);
          error_count++;
        end else begin
          queue_reply_t e;
          e = expected_replies.pop_front();
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.status);
            error_count++;
          end
          if (out_ch.out_value !== e.out_value) begin
            $error("out_value: expected %0d, got %0d", e.out_value, out_ch.out_value);
            error_count++;
          end
          if (out_ch.entry_count !== e.entry_count) begin
            $error("entry_count: expected %0d, got %0d", e.entry_count, out_ch.entry_count);
            error_count++;
          end
        end
      end
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (recv_idle > 0) begin
        out_ch.ready <= 1'b0;
        recv_idle    <= recv_idle - 1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        recv_idle    <= $urandom_range(0, 9);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // long receiver stall while the sender keeps offering items
  initial begin
    int unsigned hold_cycles;
    long_hold = 1'b0;
    wait (ops_issued >= 60);
    @(posedge clk);
    long_hold <= 1'b1;
    hold_cycles = 0;
    while (hold_cycles < 120) begin
      @(posedge clk);
      hold_cycles++;
    end
    long_hold <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned n;
    int unsigned tail;
    queue_op_t   marker;
    marker.opcode        = 2'bxx;
    marker.item_value    = '0;
    marker.item_priority = '0;
    error_count = 0;
    ops_issued  = 0;
    calm_phase  = 1'b0;
    shadow_fill = 0;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_NOP;
    in_ch.item_value = '0;
    in_ch.item_priority = '0;
    out_ch.ready = 1'b0;

    // directed: empty cases, extremes, ties, fill to full, limit hits and misses
    pending_ops.push_back(make_op(OP_DEQ, 32'h0, 16'h0));
    pending_ops.push_back(make_op(OP_DEQ_LIM, 32'h0, 16'h7fff));
    pending_ops.push_back(make_op(OP_NOP, 32'hffff_ffff, 16'hffff));
    pending_ops.push_back(make_op(OP_ENQ, 32'h7fff_ffff, 16'h8000));
    pending_ops.push_back(make_op(OP_ENQ, 32'h8000_0000, 16'h7fff));
    pending_ops.push_back(make_op(OP_ENQ, 32'hffff_ffff, 16'h7fff));
    pending_ops.push_back(make_op(OP_DEQ_LIM, 32'h0, 16'h8000));
    pending_ops.push_back(make_op(OP_DEQ_LIM, 32'h0, 16'h0));
    for (int i = 0; i < 15; i++)
      pending_ops.push_back(make_op(OP_ENQ, 32'(i), 16'((i % 3) - 1)));
    pending_ops.push_back(make_op(OP_ENQ, 32'h5555_aaaa, 16'h0));
    pending_ops.push_back(make_op(OP_DEQ_LIM, 32'h0, 16'h8001));
    pending_ops.push_back(marker);
    for (int i = 0; i < 18; i++)
      pending_ops.push_back(make_op(OP_DEQ, 32'h0, 16'h0));

    n = 0;
    while (n < 620) begin
      logic [1:0] opc;
      int unsigned w;
      w = $urandom_range(0, 99);
      // alternate fill-heavy and drain-heavy stretches
      if (((n / 40) % 2) == 0)
        opc = (w < 65) ? OP_ENQ : (w < 80) ? OP_DEQ : (w < 97) ? OP_DEQ_LIM : OP_NOP;
      else
        opc = (w < 30) ? OP_ENQ : (w < 60) ? OP_DEQ : (w < 97) ? OP_DEQ_LIM : OP_NOP;
      pending_ops.push_back(make_op(opc, $urandom, rand_prio()));
      if (n == 300) pending_ops.push_back(marker);
      n++;
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_ops.size() < 60);
    calm_phase = 1'b1;
    wait (pending_ops.size() == 0 && !in_ch.valid);
    tail = 0;
    while (expected_replies.size() != 0 && tail < 10000) begin
      @(posedge clk);
      tail++;
    end
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_replies.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/tpq_pkg.sv
src/tpq_if.sv
src/tpq_ctrl.sv
src/tpq_dp.sv
src/threshold_priority_queue_top.sv
verif/tb_threshold_priority_queue_top.sv
